// ===== rtl/core/pbsb_pkg.sv =====
// Shared types and constants for the pixel box-sum binning unit.
`timescale 1ns / 1ps
`default_nettype none
package pbsb_pkg;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int PIX_W       = 8;
    localparam int SUM_W       = 12;
    localparam int DIM_W       = 12;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [DIM_W-1:0] RESET_WIDTH  = 12'd640;
    localparam logic [DIM_W-1:0] RESET_HEIGHT = 12'd480;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FACTOR = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } t_cfg_idx;

    // One classified in-block pixel, as handed from front to back
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             dx_first;    // first pixel of a block row segment
        logic             col_last;    // last pixel of a block row segment
        logic             dy_first;    // first row of the block
        logic             dy_last;     // last row of the block
        logic             row_last;    // last pixel of a segment in the last block column
        logic             frame_last;  // last block column and last block row
    } t_item;

    localparam int ITEM_W = $bits(t_item);

endpackage
`default_nettype wire

// ===== rtl/core/pixel_box_sum_binning_unit.sv =====
// Path: a block's bottom-right pixel passes the queue and block stage into the result register.
// Throughput: one pixel per cycle while the queue has room; the line store takes at most
// one read and one write each cycle, read as a beat enters the block stage and written back
// as a segment's last beat leaves it. Output stalls back up through a four-beat queue.
// Reset: synchronous active-low; registers return to 2x2, 640x480, position zero.
// The line store is not cleared; each entry is written in a block's first row before use.
`timescale 1ns / 1ps
`default_nettype none
module pixel_box_sum_binning_unit #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [pbsb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [pbsb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire                              i_pix_valid,
    output logic                             o_pix_ready,
    input  wire  [pbsb_pkg::PIX_W-1:0]       i_pixel,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic [pbsb_pkg::SUM_W-1:0]       o_block_sum,
    output logic                             o_end_of_row,
    output logic                             o_end_of_frame
);

    localparam int AW = $clog2(MAX_WIDTH / 2);
    localparam int QW = pbsb_pkg::ITEM_W + AW;

    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_valid;
    pbsb_pkg::t_item  f_item;
    logic [AW-1:0]    f_bx;
    logic [QW-1:0]    q_data;
    pbsb_pkg::t_item  q_item;
    logic [AW-1:0]    q_bx;

    // Classify incoming pixels
    pbsb_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_pix_valid (i_pix_valid),
        .i_pixel     (i_pixel),
        .o_pix_ready (o_pix_ready),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_item      (f_item),
        .o_bx        (f_bx)
    );

    // Decouple front and back
    pbsb_fifo #(
        .DATA_W (QW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_item, f_bx}),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign q_item = q_data[QW-1:AW];
    assign q_bx   = q_data[AW-1:0];

    // Accumulate blocks and emit sums
    pbsb_back #(
        .AW (AW)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_item       (q_item),
        .i_q_bx         (q_bx),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_block_sum    (o_block_sum),
        .o_end_of_row   (o_end_of_row),
        .o_end_of_frame (o_end_of_frame)
    );

endmodule
`default_nettype wire

// ===== rtl/core/pbsb_front.sv =====
// Front end: configuration registers, raster position tracking and pixel classification.
`timescale 1ns / 1ps
`default_nettype none
module pbsb_front #(
    parameter int MAX_WIDTH = 2048,
    parameter int AW        = 10
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_valid,
    input  wire  [pbsb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [pbsb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                              o_cfg_ready,
    input  wire                               i_pix_valid,
    input  wire  [pbsb_pkg::PIX_W-1:0]        i_pixel,
    output logic                              o_pix_ready,
    input  wire                               i_q_full,
    output logic                              o_push,
    output pbsb_pkg::t_item                   o_item,
    output logic [AW-1:0]                     o_bx
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int WW = XW + 1;
    localparam int DW = pbsb_pkg::DIM_W;

    logic                r_factor;
    logic [DW-1:0]       r_frame_width;
    logic [DW-1:0]       r_frame_height;
    logic [XW-1:0]       r_x;
    logic [DW-1:0]       r_y;
    logic [XW-1:0]       n_x;
    logic [DW-1:0]       n_y;

    logic [WW-1:0]       w_eff;
    logic [WW-1:0]       lim_x;
    logic [WW-1:0]       x_inc;
    logic [DW-1:0]       h_eff;
    logic [DW-1:0]       lim_y;
    logic [DW:0]         y_inc;
    logic                in_block;
    logic                accept;

    assign o_cfg_ready = 1'b1;
    assign o_pix_ready = !i_q_full;
    assign accept      = i_pix_valid && o_pix_ready;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor       <= 1'b0;
            r_frame_width  <= pbsb_pkg::RESET_WIDTH;
            r_frame_height <= pbsb_pkg::RESET_HEIGHT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pbsb_pkg::CFG_FACTOR: r_factor       <= i_cfg_data[0];
                pbsb_pkg::CFG_WIDTH:  r_frame_width  <= i_cfg_data[DW-1:0];
                pbsb_pkg::CFG_HEIGHT: r_frame_height <= i_cfg_data[DW-1:0];
                default: ;
            endcase
        end
    end

    // Clamp frame size and find the last full block column and row
    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_frame_width);
        end
        h_eff = (r_frame_height == '0) ? DW'(1) : r_frame_height;
        lim_x = r_factor ? (w_eff & ~WW'(3)) : (w_eff & ~WW'(1));
        lim_y = r_factor ? (h_eff & ~DW'(3)) : (h_eff & ~DW'(1));
        x_inc = {1'b0, r_x} + WW'(1);
        y_inc = {1'b0, r_y} + (DW+1)'(1);
    end

    // Classify the current pixel
    always_comb begin
        in_block = ({1'b0, r_x} < lim_x) && (r_y < lim_y);
        o_item.pixel      = i_pixel;
        o_item.dx_first   = r_factor ? (r_x[1:0] == 2'b00) : !r_x[0];
        o_item.col_last   = r_factor ? (r_x[1:0] == 2'b11) : r_x[0];
        o_item.dy_first   = r_factor ? (r_y[1:0] == 2'b00) : !r_y[0];
        o_item.dy_last    = r_factor ? (r_y[1:0] == 2'b11) : r_y[0];
        o_item.row_last   = (x_inc == lim_x);
        o_item.frame_last = (x_inc == lim_x) && (y_inc == {1'b0, lim_y});
        o_bx   = r_factor ? AW'(r_x >> 2) : AW'(r_x >> 1);
        o_push = accept && in_block;
    end

    // Advance the raster position
    always_comb begin
        n_x = r_x;
        n_y = r_y;
        if (x_inc >= w_eff) begin
            n_x = '0;
            n_y = (y_inc >= {1'b0, h_eff}) ? '0 : y_inc[DW-1:0];
        end else begin
            n_x = x_inc[XW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_y <= '0;
        end else if (accept) begin
            r_x <= n_x;
            r_y <= n_y;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/pbsb_fifo.sv =====
// Short queue decoupling the front end from the accumulation back end.
`timescale 1ns / 1ps
`default_nettype none
module pbsb_fifo #(
    parameter int DATA_W = 18
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    input  wire  [DATA_W-1:0]  i_data,
    input  wire                i_pop,
    output logic               o_full,
    output logic               o_valid,
    output logic [DATA_W-1:0]  o_data
);

    localparam int DEPTH = pbsb_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PW-1:0]     r_wr_ptr;
    logic [PW-1:0]     r_rd_ptr;
    logic [PW:0]       r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == (PW+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Store a beat
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Move pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (PW+1)'(1);
            end else if (!do_push && do_pop) begin
                r_count <= r_count - (PW+1)'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/pbsb_back.sv =====
// Back end: horizontal accumulation, line store update and result register.
`timescale 1ns / 1ps
`default_nettype none
module pbsb_back #(
    parameter int AW = 10
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_q_valid,
    input  pbsb_pkg::t_item                  i_q_item,
    input  wire  [AW-1:0]                    i_q_bx,
    output logic                             o_pop,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic [pbsb_pkg::SUM_W-1:0]       o_block_sum,
    output logic                             o_end_of_row,
    output logic                             o_end_of_frame
);

    localparam int SW    = pbsb_pkg::SUM_W;
    localparam int DEPTH = 1 << AW;

    logic [SW-1:0]    r_mem [DEPTH];
    logic [SW-1:0]    r_rd;
    logic [SW-1:0]    r_hacc;
    logic [SW-1:0]    n_hacc;

    logic             r_b_valid;
    pbsb_pkg::t_item  r_b_item;
    logic [AW-1:0]    r_b_bx;
    logic [SW-1:0]    r_b_hsum;

    logic             r_o_valid;
    logic [SW-1:0]    r_o_sum;
    logic             r_o_eor;
    logic             r_o_eof;

    logic             en;
    logic             b_write;
    logic             b_out;
    logic [SW-1:0]    sum;

    // Pipeline moves whenever the result register is free or being drained
    assign en    = !r_o_valid || i_out_ready;
    assign o_pop = en && i_q_valid;

    always_comb begin
        n_hacc  = i_q_item.dx_first ? SW'(i_q_item.pixel) : r_hacc + SW'(i_q_item.pixel);
        sum     = r_b_item.dy_first ? r_b_hsum : r_rd + r_b_hsum;
        b_write = en && r_b_valid && r_b_item.col_last;
        b_out   = r_b_valid && r_b_item.col_last && r_b_item.dy_last;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hacc    <= '0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= o_pop;
            r_o_valid <= b_out;
            if (o_pop) begin
                r_hacc <= n_hacc;
            end
        end
    end

    // Payload stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (o_pop) begin
                r_b_item <= i_q_item;
                r_b_bx   <= i_q_bx;
                r_b_hsum <= n_hacc;
            end
            if (b_out) begin
                r_o_sum <= sum;
                r_o_eor <= r_b_item.row_last;
                r_o_eof <= r_b_item.frame_last;
            end
        end
    end

    // Line store of partial block sums: read on pop, write back in next stage
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd <= r_mem[i_q_bx];
        end
        if (b_write) begin
            r_mem[r_b_bx] <= sum;
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_block_sum    = r_o_sum;
    assign o_end_of_row   = r_o_eor;
    assign o_end_of_frame = r_o_eof;

endmodule
`default_nettype wire

// ===== sim/tb_pixel_box_sum_binning_unit.sv =====
// Self-checking testbench for the pixel box-sum binning unit.
`timescale 1ns / 1ps
module tb_pixel_box_sum_binning_unit;

    localparam int MAX_LINE      = 2048;
    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int SW            = pbsb_pkg::SUM_W;
    localparam int PW            = pbsb_pkg::PIX_W;
    localparam int DW            = pbsb_pkg::DIM_W;
    localparam int CW            = pbsb_pkg::CFG_DATA_W;
    localparam int IW            = pbsb_pkg::CFG_IDX_W;

    typedef struct {
        logic [SW-1:0] sum;
        logic          eor;
        logic          eof;
    } t_block_result;

    logic            i_clk = 1'b0;
    logic            i_rst_n;
    logic            i_cfg_valid;
    logic            o_cfg_ready;
    logic [IW-1:0]   i_cfg_index;
    logic [CW-1:0]   i_cfg_data;
    logic            i_pix_valid;
    logic            o_pix_ready;
    logic [PW-1:0]   i_pixel;
    logic            o_out_valid;
    logic            i_out_ready = 1'b0;
    logic [SW-1:0]   o_block_sum;
    logic            o_end_of_row;
    logic            o_end_of_frame;

    // Mirror of the binning state
    logic          bin_factor;
    logic [DW-1:0] frame_w;
    logic [DW-1:0] frame_h;
    logic [SW-1:0] column_sums [0:MAX_LINE/2-1];
    logic [SW-1:0] line_acc;
    logic [10:0]   col_pos;
    logic [11:0]   row_pos;

    t_block_result pending_blocks [$];
    int            pixels_sent;
    int            blocks_predicted;
    int            errors;
    int            cycle_count;
    int            stall_left;
    bit            pix_gaps_on;
    bit            out_stalls_on;

    pixel_box_sum_binning_unit #(
        .MAX_WIDTH(MAX_LINE)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_pix_valid   (i_pix_valid),
        .o_pix_ready   (o_pix_ready),
        .i_pixel       (i_pixel),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_block_sum   (o_block_sum),
        .o_end_of_row  (o_end_of_row),
        .o_end_of_frame(o_end_of_frame)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int pick_idle_len();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 55) return 0;
        if (r < 85) return int'($urandom_range(1, 2));
        if (r < 97) return int'($urandom_range(3, 6));
        return int'($urandom_range(10, 30));
    endfunction

    function automatic logic [PW-1:0] rand_pixel();
        int r;
        r = int'($urandom_range(0, 9));
        if (r == 0) return '0;
        if (r == 1) return '1;
        return PW'($urandom_range(0, 255));
    endfunction

    function automatic logic [DW-1:0] pick_dim();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 72) return DW'($urandom_range(1, 12));
        if (r < 90) return DW'($urandom_range(13, 40));
        return '0;
    endfunction

    // Advance the mirror by one pixel and queue the block sum it completes
    task automatic bin_pixel(input logic [PW-1:0] pix);
        int w, h, blk, nbx, nby, x, y, dx, dy, bx;
        logic [SW-1:0] sum;
        t_block_result res;
        w = (frame_w == 0) ? 1 : ((frame_w > MAX_LINE) ? MAX_LINE : int'(frame_w));
        h = (frame_h == 0) ? 1 : int'(frame_h);
        blk = bin_factor ? 4 : 2;
        nbx = w / blk;
        nby = h / blk;
        x = int'(col_pos);
        y = int'(row_pos);
        if (x < nbx * blk && y < nby * blk) begin
            dx = x % blk;
            dy = y % blk;
            bx = x / blk;
            if (dx == 0) line_acc = SW'(pix);
            else line_acc = line_acc + SW'(pix);
            // fold the row segment into the column partial sum at the block's right edge
            if (dx == blk - 1) begin
                sum = (dy == 0) ? line_acc : column_sums[bx] + line_acc;
                column_sums[bx] = sum;
                if (dy == blk - 1) begin
                    res.sum = sum;
                    res.eor = (bx == nbx - 1);
                    res.eof = res.eor && (y / blk == nby - 1);
                    pending_blocks.push_back(res);
                    blocks_predicted++;
                end
            end
        end
        if (x + 1 >= w) begin
            col_pos = '0;
            row_pos = (y + 1 >= h) ? '0 : 12'(y + 1);
        end else begin
            col_pos = 11'(x + 1);
        end
    endtask

    task automatic send_pixel(input logic [PW-1:0] pix);
        int gap;
        gap = pix_gaps_on ? pick_idle_len() : 0;
        if (gap > 0) begin
            i_pix_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_pix_valid <= 1'b1;
        i_pixel     <= pix;
        do @(posedge i_clk); while (!o_pix_ready);
        bin_pixel(pix);
        pixels_sent++;
    endtask

    // Hold the pixel side until every queued block sum has come out
    task automatic drain_blocks();
        i_pix_valid <= 1'b0;
        while (pending_blocks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(input pbsb_pkg::t_cfg_idx idx, input logic [CW-1:0] value);
        drain_blocks();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            pbsb_pkg::CFG_FACTOR: bin_factor = value[0];
            pbsb_pkg::CFG_WIDTH:  frame_w    = value;
            pbsb_pkg::CFG_HEIGHT: frame_h    = value;
            default: ;
        endcase
    endtask

    task automatic configure(input logic f, input logic [DW-1:0] w,
                             input logic [DW-1:0] h);
        set_reg(pbsb_pkg::CFG_FACTOR, {{(CW-1){1'b0}}, f});
        set_reg(pbsb_pkg::CFG_WIDTH, w);
        set_reg(pbsb_pkg::CFG_HEIGHT, h);
    endtask

    // Send until column zero of a frame start, or of a row a multiple of four, which starts a block row
    task automatic run_to(input bit frame_start);
        while (!(col_pos == 0 && (frame_start ? row_pos == 0 : row_pos[1:0] == 2'b00)))
            send_pixel(rand_pixel());
    endtask

    task automatic send_frame();
        send_pixel(rand_pixel());
        run_to(1'b1);
    endtask

    // Reset values: 2x2 blocks and a row longer than 40 pixels, then a 44x2 frame
    task automatic test_reset_defaults();
        repeat (40) send_pixel(rand_pixel());
        // positions are kept, so row 0 simply continues under the new size
        set_reg(pbsb_pkg::CFG_HEIGHT, 12'd2);
        set_reg(pbsb_pkg::CFG_WIDTH, 12'd44);
        run_to(1'b1);
    endtask

    task automatic test_extreme_pixels();
        configure(1'b1, 12'd4, 12'd4);
        repeat (16) send_pixel('1);
        configure(1'b0, 12'd2, 12'd2);
        repeat (4) send_pixel('0);
        repeat (4) send_pixel('1);
    endtask

    // Frames too small for a block, clamped sizes, partial block rows and columns
    task automatic test_small_frames();
        configure(1'b0, 12'd1, 12'd1);
        send_frame();
        configure(1'b1, 12'd3, 12'd3);
        send_frame();
        configure(1'b0, 12'd5, 12'd5);
        send_frame();
        configure(1'b1, 12'd0, 12'd0);
        send_frame();
        configure(1'b1, 12'd4, 12'd3);
        send_frame();
        configure(1'b1, 12'd7, 12'd9);
        send_frame();
        configure(1'b0, 12'd3, 12'd2);
        send_frame();
    endtask

    // Width above the line limit acts as the limit, so row 0 runs past ten pixels
    task automatic test_wide_frame();
        configure(1'b0, 12'd4095, 12'd2);
        repeat (10) send_pixel(rand_pixel());
        // column 10 lies beyond the new width and wraps to row 1
        set_reg(pbsb_pkg::CFG_WIDTH, 12'd10);
        run_to(1'b1);
    endtask

    // Tallest frame, cut short at a block row start
    task automatic test_tall_frame();
        configure(1'b0, 12'd2, 12'd4095);
        repeat (40) send_pixel(rand_pixel());
        set_reg(pbsb_pkg::CFG_HEIGHT, 12'd20);
        run_to(1'b1);
    endtask

    task automatic test_random_frames();
        int start_pix, mode, k;
        start_pix = pixels_sent;
        while (pixels_sent - start_pix < 200) begin
            pix_gaps_on   = ($urandom_range(0, 3) != 0);
            out_stalls_on = ($urandom_range(0, 3) != 0);
            configure(1'($urandom_range(0, 1)), pick_dim(), pick_dim());
            mode = int'($urandom_range(0, 9));
            k = int'($urandom_range(1, 40));
            if (mode == 0) begin
                // cut the frame short at a block row start with new settings
                repeat (k) send_pixel(rand_pixel());
                run_to(1'b0);
                configure(1'($urandom_range(0, 1)), pick_dim(), pick_dim());
                run_to(1'b1);
            end else if (mode == 1) begin
                repeat (k) send_pixel(rand_pixel());
                drain_blocks();
                run_to(1'b1);
            end else begin
                send_frame();
            end
        end
        pix_gaps_on   = 1'b1;
        out_stalls_on = 1'b1;
    endtask

    // Check each block sum beat and choose the next ready level
    always @(posedge i_clk) begin : out_side
        t_block_result want;
        int n;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready) begin
            if (pending_blocks.size() == 0) begin
                $display("%0t: unexpected block beat, sum %0d eor %0b eof %0b", $time,
                         o_block_sum, o_end_of_row, o_end_of_frame);
                errors++;
            end else begin
                want = pending_blocks.pop_front();
                if (o_block_sum !== want.sum) begin
                    $display("%0t: block_sum expected %0d, got %0d", $time, want.sum,
                             o_block_sum);
                    errors++;
                end
                if (o_end_of_row !== want.eor) begin
                    $display("%0t: end_of_row expected %0b, got %0b", $time, want.eor,
                             o_end_of_row);
                    errors++;
                end
                if (o_end_of_frame !== want.eof) begin
                    $display("%0t: end_of_frame expected %0b, got %0b", $time, want.eof,
                             o_end_of_frame);
                    errors++;
                end
            end
        end
        if (!out_stalls_on) begin
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            n = pick_idle_len();
            i_out_ready <= (n == 0);
            stall_left = (n > 0) ? n - 1 : 0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= pbsb_pkg::CFG_FACTOR;
        i_cfg_data  <= '0;
        i_pix_valid <= 1'b0;
        i_pixel     <= '0;
        bin_factor  = 1'b0;
        frame_w     = pbsb_pkg::RESET_WIDTH;
        frame_h     = pbsb_pkg::RESET_HEIGHT;
        line_acc    = '0;
        col_pos     = '0;
        row_pos     = '0;
        pixels_sent      = 0;
        blocks_predicted = 0;
        errors           = 0;
        cycle_count      = 0;
        stall_left       = 0;
        pix_gaps_on      = 1'b1;
        out_stalls_on    = 1'b1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_extreme_pixels();
        test_small_frames();
        test_wide_frame();
        test_tall_frame();
        test_random_frames();

        drain_blocks();
        repeat (8) @(posedge i_clk);
        if (errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule
